[src/hpt_pkg.sv]
// Shared constants, result codes and the front-to-back command type of the hashed page table.
`default_nettype none

package hpt_pkg;

   localparam int BUCKETS     = 16;
   localparam int WAYS        = 4;
   localparam int PAGE_BITS   = 20;
   localparam int FRAME_BITS  = 20;

   // fixed port field widths
   localparam int FIELD_W     = 20;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 6;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

   typedef struct packed {
      logic valid;
      logic is_insert;
   } cmd_type;

endpackage

`default_nettype wire

[src/hpt_front.sv]
// Front end: accepts requests, works out the bucket index and queues them for the back end.
`default_nettype none

module hpt_front #(
   parameter int BUCKETS    = hpt_pkg::BUCKETS,
   parameter int PAGE_BITS  = hpt_pkg::PAGE_BITS,
   parameter int FRAME_BITS = hpt_pkg::FRAME_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic                       in_insert,
   input  wire logic [PAGE_BITS-1:0]       in_page,
   input  wire logic [FRAME_BITS-1:0]      in_frame,
   output hpt_pkg::cmd_type                q_cmd,
   output logic [$clog2(BUCKETS)-1:0]      q_bucket,
   output logic [PAGE_BITS-1:0]            q_page,
   output logic [FRAME_BITS-1:0]           q_frame,
   input  wire logic                       q_ready
);

   localparam int  BKT_W    = $clog2(BUCKETS);
   localparam bit  POW2     = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam int  DIG_W    = 4;
   localparam int  DIG_VALS = 2 ** DIG_W;
   localparam int  NDIG     = (PAGE_BITS + DIG_W - 1) / DIG_W;
   localparam int  DIG_IW   = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int  CNT_W    = $clog2(NDIG + 1);
   localparam int  QD       = hpt_pkg::QUEUE_DEPTH;
   localparam int  QP_W     = (QD > 1) ? $clog2(QD) : 1;
   localparam int  QC_W     = $clog2(QD + 1);
   localparam logic [BKT_W:0]   BKT_DIV  = (BKT_W + 1)'(BUCKETS);
   localparam logic [CNT_W-1:0] DIV_LOAD = POW2 ? '0 : CNT_W'(NDIG);

   // residue of every digit value at every digit position, modulo the bucket count
   typedef logic [NDIG-1:0][DIG_VALS-1:0][BKT_W-1:0] res_tab_type;

   function automatic res_tab_type residue_table();
      res_tab_type tab;
      int weight;
      weight = 1;
      for (int p = 0; p < NDIG; p++) begin
         for (int v = 0; v < DIG_VALS; v++) begin
            tab[p][v] = BKT_W'((v * weight) % BUCKETS);
         end
         weight = (weight * DIG_VALS) % BUCKETS;
      end
      return tab;
   endfunction

   localparam res_tab_type RES_TAB = residue_table();

   // holding stage; bucket counts that are not a power of two fold the page in one digit a cycle
   logic                  hold_valid_ff, hold_valid_in;
   logic                  hold_insert_ff;
   logic [PAGE_BITS-1:0]  hold_page_ff;
   logic [FRAME_BITS-1:0] hold_frame_ff;
   logic [CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic [BKT_W-1:0]      rem_ff, rem_in;

   logic [CNT_W-1:0]              cnt_m1;
   logic [NDIG-1:0][DIG_W-1:0]    page_digits;
   logic [DIG_W-1:0]              digit;
   logic [BKT_W-1:0]              digit_res;
   logic [BKT_W:0]                rem_sum;
   logic [PAGE_BITS+BKT_W-1:0]    page_ext;
   logic [BKT_W-1:0]              bucket_calc;
   logic                          accept;
   logic                          push;
   logic                          pop;

   // queue
   logic                  qi_ff [QD];
   logic [BKT_W-1:0]      qb_ff [QD];
   logic [PAGE_BITS-1:0]  qp_ff [QD];
   logic [FRAME_BITS-1:0] qf_ff [QD];
   logic [QP_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]       q_cnt_ff, q_cnt_in;
   logic                  q_full;

   assign q_full   = q_cnt_ff == QC_W'(QD);
   assign push     = hold_valid_ff && (div_cnt_ff == '0) && !q_full;
   assign in_ready = !hold_valid_ff || push;
   assign accept   = in_valid && in_ready;

   assign cnt_m1      = div_cnt_ff - CNT_W'(1);
   assign page_digits = (NDIG * DIG_W)'(hold_page_ff);
   assign digit       = page_digits[cnt_m1[DIG_IW-1:0]];
   assign digit_res   = RES_TAB[cnt_m1[DIG_IW-1:0]][digit];
   assign rem_sum     = {1'b0, rem_ff} + {1'b0, digit_res};
   assign page_ext    = (PAGE_BITS + BKT_W)'(hold_page_ff);
   assign bucket_calc = POW2 ? page_ext[BKT_W-1:0] : rem_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      div_cnt_in    = div_cnt_ff;
      rem_in        = rem_ff;
      if (hold_valid_ff && div_cnt_ff != '0) begin
         div_cnt_in = cnt_m1;
         rem_in     = (rem_sum >= BKT_DIV) ? BKT_W'(rem_sum - BKT_DIV) : BKT_W'(rem_sum);
      end
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         div_cnt_in    = DIV_LOAD;
         rem_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         div_cnt_ff    <= div_cnt_in;
      end
      rem_ff <= rem_in;
      if (accept) begin
         hold_insert_ff <= in_insert;
         hold_page_ff   <= in_page;
         hold_frame_ff  <= in_frame;
      end
   end

   assign pop = q_cmd.valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QD - 1)) ? '0 : wr_ptr_ff + QP_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QD - 1)) ? '0 : rd_ptr_ff + QP_W'(1);
      end
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + QC_W'(1);
      end else if (pop && !push) begin
         q_cnt_in = q_cnt_ff - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
      if (push) begin
         qi_ff[wr_ptr_ff] <= hold_insert_ff;
         qb_ff[wr_ptr_ff] <= bucket_calc;
         qp_ff[wr_ptr_ff] <= hold_page_ff;
         qf_ff[wr_ptr_ff] <= hold_frame_ff;
      end
   end

   assign q_cmd.valid     = q_cnt_ff != '0;
   assign q_cmd.is_insert = qi_ff[rd_ptr_ff];
   assign q_bucket        = qb_ff[rd_ptr_ff];
   assign q_page          = qp_ff[rd_ptr_ff];
   assign q_frame         = qf_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[src/hpt_back.sv]
// Back end: bucket memory, slot compare, write back, collision count and result register.
`default_nettype none

module hpt_back #(
   parameter int BUCKETS    = hpt_pkg::BUCKETS,
   parameter int WAYS       = hpt_pkg::WAYS,
   parameter int PAGE_BITS  = hpt_pkg::PAGE_BITS,
   parameter int FRAME_BITS = hpt_pkg::FRAME_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hpt_pkg::cmd_type                  q_cmd,
   input  wire logic [$clog2(BUCKETS)-1:0]        q_bucket,
   input  wire logic [PAGE_BITS-1:0]              q_page,
   input  wire logic [FRAME_BITS-1:0]             q_frame,
   output logic                                   q_ready,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [hpt_pkg::STATUS_W-1:0]           out_status,
   output logic [hpt_pkg::FIELD_W-1:0]            out_frame,
   output logic [hpt_pkg::COUNT_W-1:0]            out_collisions
);

   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int FILL_W = $clog2(WAYS + 1);
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CW     = hpt_pkg::COUNT_W;

   typedef logic [WAYS-1:0][PAGE_BITS-1:0]  pages_type;
   typedef logic [WAYS-1:0][FRAME_BITS-1:0] frames_type;

   // bucket memory: fill count plus page and frame rows
   logic [FILL_W-1:0] fill_mem  [BUCKETS];
   pages_type         page_mem  [BUCKETS];
   frames_type        frame_mem [BUCKETS];

   logic              clear_done_ff;
   logic [BKT_W-1:0]  clear_cnt_ff;

   logic [FILL_W-1:0] rd_fill_ff;
   pages_type         rd_pages_ff;
   frames_type        rd_frames_ff;

   logic              byp_ff, byp_in;
   logic [FILL_W-1:0] byp_fill_ff;
   pages_type         byp_pages_ff;
   frames_type        byp_frames_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_insert_ff;
   logic [BKT_W-1:0]      s1_bucket_ff;
   logic [PAGE_BITS-1:0]  s1_page_ff;
   logic [FRAME_BITS-1:0] s1_frame_ff;

   logic [CW-1:0]         coll_ff, coll_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hpt_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [hpt_pkg::FIELD_W-1:0]   rsp_frame_ff;

   logic              out_free;
   logic              s1_advance;
   logic              q_pop;

   logic [FILL_W-1:0] cur_fill;
   pages_type         cur_pages;
   frames_type        cur_frames;
   logic              match_found;
   logic [WAY_W-1:0]  match_idx;
   logic              bucket_full;
   logic [WAY_W-1:0]  free_idx;

   logic              wr_en;
   logic [FILL_W-1:0] new_fill;
   pages_type         new_pages;
   frames_type        new_frames;
   logic [hpt_pkg::STATUS_W-1:0] status_calc;
   logic [FRAME_BITS-1:0]        frame_calc;

   assign out_free   = !rsp_valid_ff || out_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign q_ready    = clear_done_ff && (!s1_valid_ff || s1_advance);
   assign q_pop      = q_cmd.valid && q_ready;

   assign cur_fill   = byp_ff ? byp_fill_ff   : rd_fill_ff;
   assign cur_pages  = byp_ff ? byp_pages_ff  : rd_pages_ff;
   assign cur_frames = byp_ff ? byp_frames_ff : rd_frames_ff;

   assign bucket_full = cur_fill >= FILL_W'(WAYS);
   assign free_idx    = WAY_W'(cur_fill);

   // lowest matching valid slot
   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (FILL_W'(w) < cur_fill && cur_pages[w] == s1_page_ff) begin
            match_found = 1'b1;
            match_idx   = WAY_W'(w);
         end
      end
   end

   always_comb begin
      wr_en       = 1'b0;
      new_fill    = cur_fill;
      new_pages   = cur_pages;
      new_frames  = cur_frames;
      coll_in     = coll_ff;
      frame_calc  = '0;
      status_calc = hpt_pkg::ST_MISS;
      if (!s1_insert_ff) begin
         if (match_found) begin
            status_calc = hpt_pkg::ST_HIT;
            frame_calc  = cur_frames[match_idx];
         end
      end else if (match_found) begin
         status_calc           = hpt_pkg::ST_UPDATED;
         wr_en                 = 1'b1;
         new_frames[match_idx] = s1_frame_ff;
      end else if (!bucket_full) begin
         status_calc          = hpt_pkg::ST_INSERTED;
         wr_en                = 1'b1;
         new_fill             = cur_fill + FILL_W'(1);
         new_pages[free_idx]  = s1_page_ff;
         new_frames[free_idx] = s1_frame_ff;
         if (cur_fill != '0 && coll_ff != hpt_pkg::COUNT_MAX) begin
            coll_in = coll_ff + CW'(1);
         end
      end else begin
         status_calc = hpt_pkg::ST_FULL;
      end
   end

   // the row written this cycle is forwarded when the next read hits the same bucket
   always_comb begin
      byp_in = byp_ff;
      if (q_pop) begin
         byp_in = s1_advance && (q_bucket == s1_bucket_ff);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (!clear_done_ff) begin
         fill_mem[clear_cnt_ff] <= '0;
      end else if (s1_advance && wr_en) begin
         fill_mem[s1_bucket_ff]  <= new_fill;
         page_mem[s1_bucket_ff]  <= new_pages;
         frame_mem[s1_bucket_ff] <= new_frames;
      end
      if (q_pop) begin
         rd_fill_ff   <= fill_mem[q_bucket];
         rd_pages_ff  <= page_mem[q_bucket];
         rd_frames_ff <= frame_mem[q_bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_done_ff <= 1'b0;
         clear_cnt_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byp_ff        <= 1'b0;
         coll_ff       <= '0;
      end else begin
         if (!clear_done_ff) begin
            clear_cnt_ff <= clear_cnt_ff + BKT_W'(1);
            if (clear_cnt_ff == BKT_W'(BUCKETS - 1)) begin
               clear_done_ff <= 1'b1;
            end
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byp_ff       <= byp_in;
         if (s1_advance) begin
            coll_ff <= coll_in;
         end
      end
      if (q_pop) begin
         s1_insert_ff  <= q_cmd.is_insert;
         s1_bucket_ff  <= q_bucket;
         s1_page_ff    <= q_page;
         s1_frame_ff   <= q_frame;
         byp_fill_ff   <= new_fill;
         byp_pages_ff  <= new_pages;
         byp_frames_ff <= new_frames;
      end
      if (s1_advance) begin
         rsp_status_ff <= status_calc;
         rsp_frame_ff  <= hpt_pkg::FIELD_W'(frame_calc);
      end
   end

   assign out_valid      = rsp_valid_ff;
   assign out_status     = rsp_status_ff;
   assign out_frame      = rsp_frame_ff;
   assign out_collisions = coll_ff;

   a_no_pop_in_clear : assert property (@(posedge clock) disable iff (reset)
      !clear_done_ff |-> !q_pop)
      else $error("request issued during clearing pass");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> cur_fill <= FILL_W'(WAYS))
      else $error("bucket fill count above way count");

   a_coll_on_insert : assert property (@(posedge clock) disable iff (reset)
      (coll_ff != $past(coll_ff)) |-> $past(s1_advance && s1_insert_ff))
      else $error("collision count moved without an insert");

   a_rsp_from_stage : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a request in the compare stage");

endmodule

`default_nettype wire

[src/hashed_page_table_unit.sv]
// Top level of the hashed page table: stream ports, front end and back end.
//
// Hashed page table with bounded chaining: a request either looks up a virtual page or
// inserts/updates a mapping; the page selects bucket page mod BUCKETS, each holding up to
// WAYS slots filled lowest first. Every request gives exactly one response with a status,
// the frame on a lookup hit (zero otherwise) and the running collision count. When BUCKETS
// is a power of two, a request is accepted each cycle and the back end sustains one per
// cycle while the response side does not stall: one registered read of the whole bucket
// row, then a compare and write-back stage that overlaps the next read (a row written
// back is forwarded to a read of the same bucket). A request passes the holding register,
// the queue, the compare stage and the response register. For other bucket counts the
// front end forms the bucket index from a constant residue table, one four-bit page digit
// a cycle, and takes no new request until the held one has its index. After reset a
// clearing pass empties the fill count of every bucket; no request reaches the table
// before it ends.
`default_nettype none

module hashed_page_table_unit #(
   parameter int BUCKETS    = hpt_pkg::BUCKETS,
   parameter int WAYS       = hpt_pkg::WAYS,
   parameter int PAGE_BITS  = hpt_pkg::PAGE_BITS,
   parameter int FRAME_BITS = hpt_pkg::FRAME_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [19:0] page number, [39:20] frame number
   input  wire logic [hpt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] req_type
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [19:0] frame_out, [25:20] collision_total, [31:26] zero
   output logic [hpt_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // [2:0] status
   output logic [hpt_pkg::STATUS_W-1:0]            rsp_tuser
);

   localparam int FW = hpt_pkg::FIELD_W;

   hpt_pkg::cmd_type                 q_cmd;
   logic [$clog2(BUCKETS)-1:0]       q_bucket;
   logic [PAGE_BITS-1:0]             q_page;
   logic [FRAME_BITS-1:0]            q_frame;
   logic                             q_ready;
   logic [PAGE_BITS-1:0]             in_page;
   logic [FRAME_BITS-1:0]            in_frame;
   logic [FW-1:0]                    out_frame;
   logic [hpt_pkg::COUNT_W-1:0]      out_collisions;

   assign in_page  = PAGE_BITS'(req_tdata[FW-1:0]);
   assign in_frame = FRAME_BITS'(req_tdata[2*FW-1:FW]);

   hpt_front #(
      .BUCKETS    (BUCKETS),
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_insert (req_tuser),
      .in_page   (in_page),
      .in_frame  (in_frame),
      .q_cmd     (q_cmd),
      .q_bucket  (q_bucket),
      .q_page    (q_page),
      .q_frame   (q_frame),
      .q_ready   (q_ready)
   );

   hpt_back #(
      .BUCKETS    (BUCKETS),
      .WAYS       (WAYS),
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_cmd          (q_cmd),
      .q_bucket       (q_bucket),
      .q_page         (q_page),
      .q_frame        (q_frame),
      .q_ready        (q_ready),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_status     (rsp_tuser),
      .out_frame      (out_frame),
      .out_collisions (out_collisions)
   );

   assign rsp_tdata = {(hpt_pkg::RSP_DATA_W - FW - hpt_pkg::COUNT_W)'(0),
                       out_collisions, out_frame};

endmodule

`default_nettype wire
